// ===== rtl/text_visible_formatter_unit_assert.svh =====
// assertion macros used by the checker file
// clock is aclk, reset is aresetn (synchronous, active low)
`ifndef TEXT_VISIBLE_FORMATTER_UNIT_ASSERT_SVH
`define TEXT_VISIBLE_FORMATTER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define TVF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// what must hold the cycle after reset is seen
`define TVF_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tvf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_pkg
// Types and character constants shared by the text formatter modules.
// ----------------------------------------------------------------------------
package tvf_pkg;

    typedef logic [7:0] tvf_byte_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_LINES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_LINE_ENDS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // characters
    localparam tvf_byte_t CH_TAB    = 8'h09;
    localparam tvf_byte_t CH_NL     = 8'h0A;
    localparam tvf_byte_t CH_SPACE  = 8'h20;
    localparam tvf_byte_t CH_DOLLAR = 8'h24;
    localparam tvf_byte_t CH_DASH   = 8'h2D;
    localparam tvf_byte_t CH_ZERO   = 8'h30;
    localparam tvf_byte_t CH_QMARK  = 8'h3F;
    localparam tvf_byte_t CH_I      = 8'h49;
    localparam tvf_byte_t CH_M      = 8'h4D;
    localparam tvf_byte_t CH_CARET  = 8'h5E;
    localparam tvf_byte_t CH_DEL    = 8'h7F;
    localparam tvf_byte_t PRINT_LO  = 8'h20;
    localparam tvf_byte_t CTRL_BIT  = 8'h40;
    localparam tvf_byte_t LOW7_MASK = 8'h7F;

    localparam int MIN_NUM_WIDTH = 6;
    localparam int BODY_MAX      = 4;
    localparam int BODY_IDX_W    = $clog2(BODY_MAX);
    localparam int QUEUE_DEPTH   = 4;

    // classified item handed from front to back
    typedef struct packed {
        logic                         has_prefix;
        logic [BODY_IDX_W-1:0]        body_last;
        tvf_byte_t [BODY_MAX-1:0]     body;
    } tvf_cmd_t;

endpackage

// ===== rtl/tvf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_queue
// Small register queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module tvf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/tvf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_front
// Accepts input bytes, keeps line state and the line counter, and classifies
// each byte into a prefix request and up to four body bytes.
// ----------------------------------------------------------------------------
module tvf_front import tvf_pkg::*; #(
    parameter int LINE_DIGITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic                            cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tvf_byte_t                       s_data_byte,
    input  logic                            s_file_start,
    input  logic                            q_not_full,
    output logic                            q_push,
    output tvf_cmd_t                        q_cmd,
    output logic [LINE_DIGITS-1:0][3:0]     q_count,
    output logic [$clog2(LINE_DIGITS+1)-1:0] q_ndig
);

    localparam int NDIG_W = $clog2(LINE_DIGITS + 1);

    logic number_lines_reg, number_nonblank_reg, show_line_ends_reg;
    logic squeeze_blank_reg, show_tabs_reg, show_nonprinting_reg;

    logic                        after_nl_reg, after_nl_next;
    logic                        blank_reg, blank_next;
    logic [LINE_DIGITS-1:0][3:0] count_reg, count_next;

    logic                        accept;
    logic                        eff_after_nl, eff_blank;
    logic [LINE_DIGITS-1:0][3:0] eff_count, cnt_inc;
    logic                        carry;
    logic                        is_nl, is_tab;
    logic                        squeezed, do_num, do_pad;
    logic [NDIG_W-1:0]           ndig;
    tvf_byte_t                   low7, ctl_char;
    logic                        is_ctrl;
    tvf_cmd_t                    cmd;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_lines_reg     <= 1'b0;
            number_nonblank_reg  <= 1'b0;
            show_line_ends_reg   <= 1'b0;
            squeeze_blank_reg    <= 1'b0;
            show_tabs_reg        <= 1'b0;
            show_nonprinting_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUMBER_LINES:     number_lines_reg     <= cfg_wdata;
                CFG_NUMBER_NONBLANK:  number_nonblank_reg  <= cfg_wdata;
                CFG_SHOW_LINE_ENDS:   show_line_ends_reg   <= cfg_wdata;
                CFG_SQUEEZE_BLANK:    squeeze_blank_reg    <= cfg_wdata;
                CFG_SHOW_TABS:        show_tabs_reg        <= cfg_wdata;
                CFG_SHOW_NONPRINTING: show_nonprinting_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_ready = q_not_full;
    assign accept  = s_valid && q_not_full;

    // file start restarts line state before this byte
    assign eff_after_nl = s_file_start || after_nl_reg;
    assign eff_blank    = !s_file_start && blank_reg;
    assign eff_count    = s_file_start ? '0 : count_reg;

    assign is_nl  = (s_data_byte == CH_NL);
    assign is_tab = (s_data_byte == CH_TAB);

    // bcd increment, held at all nines
    always_comb begin
        carry = 1'b1;
        for (int i = 0; i < LINE_DIGITS; i++) begin
            cnt_inc[i] = eff_count[i];
            if (carry) begin
                cnt_inc[i] = (eff_count[i] >= 4'd9) ? 4'd0 : eff_count[i] + 4'd1;
            end
            carry = carry && (eff_count[i] == 4'd9);
        end
        if (carry) begin
            cnt_inc = eff_count;
        end
    end

    // significant digits of the new count
    always_comb begin
        ndig = NDIG_W'(1);
        for (int i = 0; i < LINE_DIGITS; i++) begin
            if (cnt_inc[i] != 4'd0) begin
                ndig = NDIG_W'(i + 1);
            end
        end
    end

    assign squeezed = eff_after_nl && squeeze_blank_reg && is_nl && eff_blank;
    assign do_num   = eff_after_nl && !squeezed && number_lines_reg
                      && (!number_nonblank_reg || !is_nl);
    assign do_pad   = eff_after_nl && !squeezed && number_lines_reg
                      && number_nonblank_reg && is_nl && show_line_ends_reg;

    // visible form of the byte itself
    assign low7     = s_data_byte & LOW7_MASK;
    assign is_ctrl  = (low7 < PRINT_LO) || (low7 == CH_DEL);
    assign ctl_char = (low7 == CH_DEL) ? CH_QMARK : (low7 | CTRL_BIT);

    always_comb begin
        cmd.has_prefix = do_num || do_pad;
        cmd.body       = '0;
        cmd.body_last  = '0;
        if (is_nl) begin
            if (show_line_ends_reg) begin
                cmd.body[0]   = CH_DOLLAR;
                cmd.body[1]   = CH_NL;
                cmd.body_last = BODY_IDX_W'(1);
            end else begin
                cmd.body[0] = CH_NL;
            end
        end else if (is_tab) begin
            if (show_tabs_reg) begin
                cmd.body[0]   = CH_CARET;
                cmd.body[1]   = CH_I;
                cmd.body_last = BODY_IDX_W'(1);
            end else begin
                cmd.body[0] = CH_TAB;
            end
        end else if (show_nonprinting_reg) begin
            if (s_data_byte[7]) begin
                cmd.body[0] = CH_M;
                cmd.body[1] = CH_DASH;
                if (is_ctrl) begin
                    cmd.body[2]   = CH_CARET;
                    cmd.body[3]   = ctl_char;
                    cmd.body_last = BODY_IDX_W'(3);
                end else begin
                    cmd.body[2]   = low7;
                    cmd.body_last = BODY_IDX_W'(2);
                end
            end else if (is_ctrl) begin
                cmd.body[0]   = CH_CARET;
                cmd.body[1]   = ctl_char;
                cmd.body_last = BODY_IDX_W'(1);
            end else begin
                cmd.body[0] = low7;
            end
        end else begin
            cmd.body[0] = s_data_byte;
        end
    end

    // line state update
    always_comb begin
        after_nl_next = after_nl_reg;
        blank_next    = blank_reg;
        count_next    = count_reg;
        if (accept) begin
            after_nl_next = is_nl;
            blank_next    = eff_blank;
            count_next    = do_num ? cnt_inc : eff_count;
            if (eff_after_nl && squeeze_blank_reg) begin
                blank_next = is_nl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_nl_reg <= 1'b1;
            blank_reg    <= 1'b0;
            count_reg    <= '0;
        end else begin
            after_nl_reg <= after_nl_next;
            blank_reg    <= blank_next;
            count_reg    <= count_next;
        end
    end

    // a squeezed newline is taken but produces nothing
    assign q_push  = accept && !squeezed;
    assign q_cmd   = cmd;
    assign q_count = cnt_inc;
    assign q_ndig  = do_num ? ndig : '0;

endmodule

// ===== rtl/tvf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_back
// Walks the queue head one output byte a cycle unless stalled: number prefix
// or blank pad, then the body bytes, into a registered output stage.
// ----------------------------------------------------------------------------
module tvf_back import tvf_pkg::*; #(
    parameter int LINE_DIGITS = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             head_valid,
    input  tvf_cmd_t                         head_cmd,
    input  logic [LINE_DIGITS-1:0][3:0]      head_count,
    input  logic [$clog2(LINE_DIGITS+1)-1:0] head_ndig,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tvf_byte_t                        m_out_byte,
    output logic                             m_last_of_run
);

    localparam int POS_W     = $clog2(LINE_DIGITS + BODY_MAX + 2);
    localparam int DIG_IDX_W = $clog2(LINE_DIGITS);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             m_valid_reg, m_valid_next;
    tvf_byte_t        m_out_byte_reg;
    logic             m_last_reg;

    logic [POS_W-1:0] ndig_ext, width_w, pre_len, body_pos, digit_pos;
    logic             in_prefix, last, load, emit;
    tvf_byte_t        cur_byte;

    assign ndig_ext  = POS_W'(head_ndig);
    assign width_w   = (ndig_ext < POS_W'(MIN_NUM_WIDTH)) ? POS_W'(MIN_NUM_WIDTH) : ndig_ext;
    assign pre_len   = head_cmd.has_prefix ? width_w + POS_W'(1) : '0;
    assign in_prefix = (pos_reg < pre_len);
    assign body_pos  = pos_reg - pre_len;
    assign digit_pos = width_w - POS_W'(1) - pos_reg;
    assign last      = (pos_reg == pre_len + POS_W'(head_cmd.body_last));

    always_comb begin
        if (in_prefix) begin
            if (pos_reg == width_w) begin
                cur_byte = CH_TAB;
            end else if (digit_pos >= ndig_ext) begin
                cur_byte = CH_SPACE;
            end else begin
                cur_byte = CH_ZERO + {4'b0, head_count[digit_pos[DIG_IDX_W-1:0]]};
            end
        end else begin
            cur_byte = head_cmd.body[body_pos[BODY_IDX_W-1:0]];
        end
    end

    assign load = !m_valid_reg || m_ready;
    assign emit = head_valid && load;
    assign pop  = emit && last;

    always_comb begin
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = head_valid;
        end
        if (emit) begin
            pos_next = last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_out_byte_reg <= cur_byte;
            m_last_reg     <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_last_of_run = m_last_reg;

endmodule

// ===== rtl/text_visible_formatter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_visible_formatter_unit
// Cooked text formatter: line numbers, blank squeezing, line-end marks,
// tab and non-printing byte notation.
// ----------------------------------------------------------------------------
// Output runs at one byte per cycle while the sink is ready. An input byte
// whose visible form is one byte passes at one per cycle when nothing stalls;
// a byte that expands to k output bytes (up to LINE_DIGITS + 5 with a line
// number prefix) holds the back end until all k are out, and input keeps
// flowing until the four-entry queue between front and back fills. A squeezed
// blank line is taken and gives no output. An input byte is registered in the
// queue, then in the output register, before its first output byte appears.
// The line counter is BCD of LINE_DIGITS digits, saturating at all nines.
// Configuration writes take effect at once and are meant for idle periods.
module text_visible_formatter_unit import tvf_pkg::*; #(
    parameter int LINE_DIGITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_file_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_last_of_run
);

    localparam int NDIG_W = $clog2(LINE_DIGITS + 1);
    localparam int CNT_W  = 4 * LINE_DIGITS;
    localparam int QW     = $bits(tvf_cmd_t) + CNT_W + NDIG_W;

    logic                        q_not_full, q_push, q_pop, head_valid;
    tvf_cmd_t                    q_cmd, head_cmd;
    logic [LINE_DIGITS-1:0][3:0] q_count, head_count;
    logic [NDIG_W-1:0]           q_ndig, head_ndig;
    logic [QW-1:0]               push_data, head_data;

    tvf_front #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_file_start (s_file_start),
        .q_not_full   (q_not_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd),
        .q_count      (q_count),
        .q_ndig       (q_ndig)
    );

    assign push_data = {q_cmd, q_count, q_ndig};

    tvf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (push_data),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign {head_cmd, head_count, head_ndig} = head_data;

    tvf_back #(
        .LINE_DIGITS (LINE_DIGITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_count    (head_count),
        .head_ndig     (head_ndig),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== rtl/tvf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvf_checker
// Port-level checks for the text formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_visible_formatter_unit_assert.svh"

module tvf_checker import tvf_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic                 cfg_wdata,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [7:0]           s_data_byte,
    input logic                 s_file_start,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [7:0]           m_out_byte,
    input logic                 m_last_of_run
);

    logic       np_reg, np_next;
    logic [8:0] s_payload, m_payload;
    logic       s_wait, m_wait, m_mid;
    logic       np_visible;

    // shadow of the non-printing option as written on the config port
    always_comb begin
        np_next = np_reg;
        if (cfg_we && (cfg_index == CFG_SHOW_NONPRINTING)) begin
            np_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            np_reg <= 1'b0;
        end else begin
            np_reg <= np_next;
        end
    end

    assign s_payload  = {s_data_byte, s_file_start};
    assign m_payload  = {m_out_byte, m_last_of_run};
    assign s_wait     = s_valid && !s_ready;
    assign m_wait     = m_valid && !m_ready;
    assign m_mid      = m_valid && !m_last_of_run;
    assign np_visible = (m_out_byte >= PRINT_LO && m_out_byte < CH_DEL)
                        || m_out_byte == CH_TAB || m_out_byte == CH_NL;

    `TVF_ASSERT_RESET(a_reset_idle, !m_valid, "output valid after reset")

    `TVF_ASSERT_NEXT(a_in_hold, s_wait, s_valid && $stable(s_payload), "waiting input changed")

    `TVF_ASSERT_NEXT(a_out_hold, m_wait, m_valid && $stable(m_payload), "stalled output changed")

    // a newline always closes its run
    `TVF_ASSERT_IMPL(a_nl_last, m_mid, m_out_byte != CH_NL, "newline not last of run")

    // with non-printing shown, only printable bytes, tab and newline leave
    `TVF_ASSERT_IMPL(a_np_visible, m_valid && np_reg, np_visible, "control byte leaked")

endmodule

bind text_visible_formatter_unit tvf_checker u_tvf_checker (.*);

// ===== test/tb_text_visible_formatter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_visible_formatter_unit
// Self-checking bench for the cooked text formatter. A queue-fed driver
// offers text bytes and a monitor compares every output byte against a
// formatter model kept here. Runs go through several flag settings:
// directed corner bytes first, then random text with line-heavy content.
// ----------------------------------------------------------------------------
module tb_text_visible_formatter_unit;
    import tvf_pkg::*;

    localparam int LINE_DIGITS    = 10;
    localparam int IDLE_PCT       = 38;
    localparam int RX_HOLD_CYCLES = 250;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 20;

    // indexes past the last register, written to check they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic [4*LINE_DIGITS-1:0] COUNT_FULL = {LINE_DIGITS{4'h9}};

    typedef struct {
        logic [7:0] data_byte;
        logic       file_start;
    } text_in_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
    } text_out_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic                 cfg_wdata     = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte   = '0;
    logic                 s_file_start  = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [7:0]           m_out_byte;
    logic                 m_last_of_run;

    text_in_t  raw_text_q[$];
    text_out_t visible_q[$];

    // formatter flags as last written
    logic do_number, do_nonblank, do_ends, do_squeeze, do_tabs, do_nonprint;
    // formatter line state
    logic                     at_line_head = 1'b1;
    logic                     prev_blank   = 1'b0;
    logic [4*LINE_DIGITS-1:0] line_bcd     = '0;

    int errors      = 0;
    bit no_idle     = 1'b0;
    int rx_hold_req = 0;

    text_visible_formatter_unit #(.LINE_DIGITS(LINE_DIGITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_file_start  (s_file_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    // visible form of one input byte, appended to the expected output
    function automatic void format_byte(input logic [7:0] ch_in, input logic fs);
        logic [7:0] ch;
        logic [7:0] run[$];
        logic       line_start;
        int         n;
        ch = ch_in;
        if (fs) begin
            at_line_head = 1'b1;
            prev_blank   = 1'b0;
            line_bcd     = '0;
        end
        line_start   = at_line_head;
        at_line_head = (ch == CH_NL);

        if (line_start) begin
            if (do_squeeze) begin
                if (ch == CH_NL) begin
                    if (prev_blank)
                        return;
                    prev_blank = 1'b1;
                end else begin
                    prev_blank = 1'b0;
                end
            end
            if (do_number) begin
                if (!do_nonblank || ch != CH_NL) begin
                    // bcd count, holds once every digit is nine
                    if (line_bcd != COUNT_FULL) begin
                        for (int i = 0; i < LINE_DIGITS; i++) begin
                            if (line_bcd[4*i +: 4] == 4'd9) begin
                                line_bcd[4*i +: 4] = 4'd0;
                            end else begin
                                line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                                break;
                            end
                        end
                    end
                    n = 1;
                    for (int i = 0; i < LINE_DIGITS; i++)
                        if (line_bcd[4*i +: 4] != 4'd0)
                            n = i + 1;
                    for (int i = n; i < MIN_NUM_WIDTH; i++)
                        run.push_back(CH_SPACE);
                    for (int i = n - 1; i >= 0; i--)
                        run.push_back(CH_ZERO + 8'(line_bcd[4*i +: 4]));
                    run.push_back(CH_TAB);
                end else if (do_ends) begin
                    repeat (MIN_NUM_WIDTH) run.push_back(CH_SPACE);
                    run.push_back(CH_TAB);
                end
            end
        end

        if (ch == CH_NL) begin
            if (do_ends)
                run.push_back(CH_DOLLAR);
            run.push_back(ch);
        end else if (ch == CH_TAB) begin
            if (do_tabs) begin
                run.push_back(CH_CARET);
                run.push_back(CH_I);
            end else begin
                run.push_back(ch);
            end
        end else if (do_nonprint) begin
            if (ch[7]) begin
                run.push_back(CH_M);
                run.push_back(CH_DASH);
                ch = ch & LOW7_MASK;
            end
            if (ch < PRINT_LO || ch == CH_DEL) begin
                run.push_back(CH_CARET);
                run.push_back(ch == CH_DEL ? CH_QMARK : (ch | CTRL_BIT));
            end else begin
                run.push_back(ch);
            end
        end else begin
            run.push_back(ch);
        end

        foreach (run[k])
            visible_q.push_back(text_out_t'{out_byte: run[k],
                                             last_of_run: (k == run.size() - 1)});
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_NUMBER_LINES:     do_number   = val;
            CFG_NUMBER_NONBLANK:  do_nonblank = val;
            CFG_SHOW_LINE_ENDS:   do_ends     = val;
            CFG_SQUEEZE_BLANK:    do_squeeze  = val;
            CFG_SHOW_TABS:        do_tabs     = val;
            CFG_SHOW_NONPRINTING: do_nonprint = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // flags bit order follows the register indexes
    task automatic set_flags(input logic [5:0] flags);
        write_reg(CFG_NUMBER_LINES,     flags[CFG_NUMBER_LINES]);
        write_reg(CFG_NUMBER_NONBLANK,  flags[CFG_NUMBER_NONBLANK]);
        write_reg(CFG_SHOW_LINE_ENDS,   flags[CFG_SHOW_LINE_ENDS]);
        write_reg(CFG_SQUEEZE_BLANK,    flags[CFG_SQUEEZE_BLANK]);
        write_reg(CFG_SHOW_TABS,        flags[CFG_SHOW_TABS]);
        write_reg(CFG_SHOW_NONPRINTING, flags[CFG_SHOW_NONPRINTING]);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fs = 1'b0);
        raw_text_q.push_back(text_in_t'{data_byte: b, file_start: fs});
    endtask

    task automatic queue_random_text(input int count);
        int         r;
        logic [7:0] b;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 20)      b = CH_NL;
            else if (r < 28) b = CH_TAB;
            else if (r < 52) b = 8'($urandom_range(8'h7E, 8'h20));
            else if (r < 64) b = 8'($urandom_range(8'h1F, 8'h00));
            else if (r < 70) b = ($urandom_range(1) != 0) ? CH_DEL : 8'hFF;
            else             b = 8'($urandom_range(255));
            queue_byte(b, $urandom_range(99) < 4);
        end
    endtask

    task automatic wait_drained();
        while (raw_text_q.size() != 0 || s_valid || visible_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // driver: one input transaction per handshake, model updated on acceptance
    always @(posedge aclk) begin : drive_text
        text_in_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                format_byte(s_data_byte, s_file_start);
            if (!s_valid || s_ready) begin
                if (raw_text_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = raw_text_q.pop_front();
                    s_data_byte  <= nxt.data_byte;
                    s_file_start <= nxt.file_start;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output transaction with the oldest expected byte
    int rx_hold_ack  = 0;
    int rx_hold_left = 0;
    always @(posedge aclk) begin : check_visible
        text_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (visible_q.size() == 0) begin
                    $error("unexpected output byte %h last %b", m_out_byte, m_last_of_run);
                    errors++;
                end else begin
                    want = visible_q.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, m_out_byte);
                        errors++;
                    end
                    if (m_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %b, got %b",
                               want.last_of_run, m_last_of_run);
                        errors++;
                    end
                end
            end
            if (rx_hold_req != rx_hold_ack) begin
                rx_hold_ack  = rx_hold_req;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog: cycles with work outstanding but no transaction on either side
    int stall_cycles = 0;
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)
                || (raw_text_q.size() == 0 && !s_valid && visible_q.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [5:0] flags;
        do_number   = 1'b0;
        do_nonblank = 1'b0;
        do_ends     = 1'b0;
        do_squeeze  = 1'b0;
        do_tabs     = 1'b0;
        do_nonprint = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // flags as they come out of reset
        queue_byte("a", 1'b1);
        queue_byte(CH_TAB);
        queue_byte(8'h01);
        queue_byte(8'h80);
        queue_byte(8'hFF);
        queue_byte(CH_NL);
        queue_byte(CH_NL);
        wait_drained();

        // everything on: byte extremes, control and high bytes, squeezed lines
        set_flags(6'h3F);
        queue_byte("A", 1'b1);
        queue_byte(CH_TAB);
        queue_byte(8'h00);
        queue_byte(8'h1F);
        queue_byte(CH_DEL);
        queue_byte(8'h80);
        queue_byte(8'h9F);
        queue_byte(8'hA0);
        queue_byte(8'hFF);
        queue_byte(8'h20);
        queue_byte(8'h7E);
        queue_byte(CH_NL);
        queue_byte(CH_NL);
        queue_byte(CH_NL);
        queue_byte(CH_NL);
        queue_byte("x");
        queue_byte(CH_NL);
        queue_byte(CH_NL, 1'b1);
        wait_drained();

        // numbering with blank lines left out, padded when ends are shown
        flags = '0;
        flags[CFG_NUMBER_LINES]    = 1'b1;
        flags[CFG_NUMBER_NONBLANK] = 1'b1;
        flags[CFG_SHOW_LINE_ENDS]  = 1'b1;
        set_flags(flags);
        queue_byte(CH_NL);
        queue_byte("a");
        queue_byte(CH_NL);
        queue_byte(CH_NL);
        queue_byte(CH_TAB);
        queue_byte(CH_NL);
        wait_drained();

        // nonblank without numbering does nothing; spare indexes are ignored
        write_reg(CFG_NUMBER_LINES, 1'b0);
        write_reg(CFG_IDX_SPARE_LO, 1'b1);
        write_reg(CFG_IDX_SPARE_HI, 1'b1);
        queue_byte(CH_NL);
        queue_byte("b");
        queue_byte(CH_NL);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       flags = 6'h00;
                1:       flags = 6'h3F;
                default: flags = 6'($urandom_range(63));
            endcase
            set_flags(flags);
            no_idle = (p == 2);
            if (p == 3) begin
                // output stalled for a long while so the input backs up
                rx_hold_req++;
                queue_random_text(PHASE_ITEMS);
            end else if (p == 4) begin
                // sender goes quiet until all output is out, then resumes
                queue_random_text(PHASE_ITEMS / 2);
                while (raw_text_q.size() != 0 || s_valid || visible_q.size() != 0)
                    @(posedge aclk);
                queue_random_text(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                queue_random_text(PHASE_ITEMS);
            end
            wait_drained();
        end
        no_idle = 1'b0;

        if (errors == 0 && visible_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tvf_pkg.sv
rtl/tvf_queue.sv
rtl/tvf_front.sv
rtl/tvf_back.sv
rtl/text_visible_formatter_unit.sv
rtl/tvf_checker.sv
test/tb_text_visible_formatter_unit.sv
